@@ sv/bdy_pkg.sv @@
// Shared types and constants for the Bayer demosaic to CbYCrY block.
`timescale 1ns / 1ps
package bdy_pkg;

   localparam int QDEPTH = 4;

   typedef enum logic [1:0] {
      REG_FRAME_WIDTH  = 2'd0,
      REG_FRAME_HEIGHT = 2'd1,
      REG_OUT_STRIDE   = 2'd2,
      REG_UNUSED       = 2'd3
   } bdy_reg_type;

   typedef struct packed {
      logic [7:0] raw_pixel;
      logic       frame_start;
   } bdy_req_type;

   typedef struct packed {
      logic [7:0]  out_cb;
      logic [7:0]  out_y_first;
      logic [7:0]  out_cr;
      logic [7:0]  out_y_second;
      logic [11:0] out_row;
      logic [10:0] out_col;
      logic [27:0] out_offset;
   } bdy_rsp_type;

   // one queued pair: 3x4 window (row i, column j at i*4+j), row, left column
   typedef struct packed {
      logic [11:0][7:0] win;
      logic [11:0]      row;
      logic [10:0]      col;
   } bdy_entry_type;

endpackage

@@ sv/bayer_demosaic_to_ycbcr422.sv @@
// Top level: BGGR Bayer stream to CbYCrY pairs with control registers.
//
//   channel | ports                          | carries
//   --------+--------------------------------+-----------------------------------
//   req     | req_valid/req_ready/req_data   | one raw Bayer sample + frame start
//   rsp     | rsp_valid/rsp_ready/rsp_data   | one CbYCrY word with row/col/offset
//   csr     | csr_valid/csr_ready/csr_index  | register write (width/height/stride)
//
// One sample per cycle is taken while the queue has room; in the front a sample
// goes through a line buffer read, then window update and write back.
// Results pass through the registered back-end stages after leaving the queue.
// Queue of 4 entries decouples a stalled rsp side: the front stops taking
// samples only once queue plus in-flight sample reach 4.
// Synchronous reset clears position, window, queue and pipeline valids and
// loads the register defaults; line buffers are not cleared.
`timescale 1ns / 1ps
module bayer_demosaic_to_ycbcr422 #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  bdy_pkg::bdy_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output bdy_pkg::bdy_rsp_type rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [15:0]          csr_wdata
);
   import bdy_pkg::*;

   logic [11:0]   frame_width_ff, frame_height_ff;
   logic [15:0]   out_stride_ff;
   logic          accept, b_busy, push, pop, q_valid;
   logic [2:0]    q_count;
   bdy_entry_type push_data, q_data;

   // register file, writes always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= 12'd320;
         frame_height_ff <= 12'd240;
         out_stride_ff   <= 16'd3840;
      end else if (csr_valid) begin
         case (bdy_reg_type'(csr_index))
            REG_FRAME_WIDTH:  frame_width_ff  <= csr_wdata[11:0];
            REG_FRAME_HEIGHT: frame_height_ff <= csr_wdata[11:0];
            REG_OUT_STRIDE:   out_stride_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // credit: the sample in front stage B may still need a queue slot
   assign req_ready = (q_count + 3'(b_busy)) < 3'(QDEPTH);
   assign accept    = req_valid && req_ready;

   bdy_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .req_data     (req_data),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .b_busy       (b_busy),
      .push         (push),
      .push_data    (push_data)
   );

   bdy_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .not_empty (q_valid),
      .count     (q_count),
      .pop_data  (q_data)
   );

   bdy_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_data     (q_data),
      .q_pop      (pop),
      .out_stride (out_stride_ff),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   a_credit: assert property (@(posedge clock) disable iff (reset)
      (q_count + 3'(b_busy)) <= 3'(QDEPTH)) else $error("credit exceeded");
   a_rst_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid) else $error("result after reset");
   a_push_src: assert property (@(posedge clock) disable iff (reset)
      push |-> $past(accept)) else $error("push without transfer");

endmodule

@@ sv/bdy_front.sv @@
// Front end: position tracking, line buffers, window and pair selection.
`timescale 1ns / 1ps
module bdy_front #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  bdy_pkg::bdy_req_type  req_data,
   input  logic [11:0]           frame_width,
   input  logic [11:0]           frame_height,
   output logic                  b_busy,
   output logic                  push,
   output bdy_pkg::bdy_entry_type push_data
);
   import bdy_pkg::*;

   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int CMPW = (CW + 1 > 13) ? CW + 1 : 13;

   logic [7:0]       line_two_ff [MAX_WIDTH];
   logic [7:0]       line_one_ff [MAX_WIDTH];
   logic [7:0]       rd_two_ff, rd_one_ff;
   logic [CW-1:0]    col_ff, col_in;
   logic [11:0]      row_ff, row_in;
   logic [CW-1:0]    col_cur;
   logic [11:0]      row_cur;
   logic [CMPW-1:0]  col_x, w_x, h_x, rb_x;
   logic             emit;
   logic             b_valid_ff, b_emit_ff, b_hit_ff;
   logic [CW-1:0]    b_addr_ff;
   logic [7:0]       b_pix_ff, b_fwd_two_ff, b_fwd_one_ff;
   logic [11:0]      b_row_ff;
   logic [10:0]      b_col_ff;
   logic [11:0][7:0] win_ff, win_in;
   logic [7:0]       above2, above1;

   always_comb begin
      col_cur = req_data.frame_start ? '0 : col_ff;
      row_cur = req_data.frame_start ? '0 : row_ff;
      col_x   = CMPW'(col_cur);
      h_x     = CMPW'(frame_height);
      if (CMPW'(frame_width) < CMPW'(MAX_WIDTH)) begin
         w_x = CMPW'(frame_width);
      end else begin
         w_x = CMPW'(MAX_WIDTH);
      end
      rb_x = CMPW'((row_cur - 12'd1) & ~12'd1);
      emit = (row_cur >= 12'd3) && (col_x >= CMPW'(4)) && !col_cur[0] && (w_x >= CMPW'(3))
             && ((col_x - CMPW'(2)) < (w_x - CMPW'(2))) && (h_x >= CMPW'(3))
             && (rb_x < (h_x - CMPW'(2)));
      if ((col_x + CMPW'(1)) >= w_x) begin
         col_in = '0;
         row_in = (row_cur < 12'd4095) ? row_cur + 12'd1 : row_cur;
      end else begin
         col_in = col_cur + CW'(1);
         row_in = row_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         b_valid_ff <= 1'b0;
         win_ff     <= '0;
      end else begin
         b_valid_ff <= accept;
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         if (b_valid_ff) begin
            win_ff <= win_in;
         end
      end
   end

   // stage B writes back; a read of the same entry in that cycle is forwarded
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_two_ff    <= line_two_ff[col_cur];
         rd_one_ff    <= line_one_ff[col_cur];
         b_addr_ff    <= col_cur;
         b_pix_ff     <= req_data.raw_pixel;
         b_emit_ff    <= emit;
         b_row_ff     <= row_cur - 12'd1;
         b_col_ff     <= 11'(col_cur - CW'(2));
         b_hit_ff     <= b_valid_ff && (b_addr_ff == col_cur);
         b_fwd_two_ff <= above1;
         b_fwd_one_ff <= b_pix_ff;
      end
      if (b_valid_ff) begin
         line_two_ff[b_addr_ff] <= above1;
         line_one_ff[b_addr_ff] <= b_pix_ff;
      end
   end

   always_comb begin
      above2 = b_hit_ff ? b_fwd_two_ff : rd_two_ff;
      above1 = b_hit_ff ? b_fwd_one_ff : rd_one_ff;
      win_in = win_ff;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            win_in[i*4+j] = win_ff[i*4+j+1];
         end
      end
      win_in[3]  = above2;
      win_in[7]  = above1;
      win_in[11] = b_pix_ff;
      push_data.win = win_in;
      push_data.row = b_row_ff;
      push_data.col = b_col_ff;
   end

   assign push   = b_valid_ff && b_emit_ff;
   assign b_busy = b_valid_ff;

endmodule

@@ sv/bdy_queue.sv @@
// Short queue of pixel-pair windows between front and back end.
`timescale 1ns / 1ps
module bdy_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  bdy_pkg::bdy_entry_type push_data,
   input  logic                   pop,
   output logic                   not_empty,
   output logic [2:0]             count,
   output bdy_pkg::bdy_entry_type pop_data
);
   import bdy_pkg::*;

   bdy_entry_type mem_ff [QDEPTH];
   logic [1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [2:0]    count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 2'd1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 2'd1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 3'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign not_empty = (count_ff != 3'd0);
   assign count     = count_ff;
   assign pop_data  = mem_ff[rd_ptr_ff];

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && !pop && count_ff == 3'(QDEPTH))) else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && count_ff == 3'd0)) else $error("queue underflow");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'(QDEPTH)) else $error("queue count out of range");

endmodule

@@ sv/bdy_back.sv @@
// Back end: bilinear colors, luma, chroma and byte offset, four stages.
`timescale 1ns / 1ps
module bdy_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  bdy_pkg::bdy_entry_type q_data,
   output logic                   q_pop,
   input  logic [15:0]            out_stride,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output bdy_pkg::bdy_rsp_type   rsp_data
);
   import bdy_pkg::*;

   logic        en;
   logic        v1_ff, v2_ff, v3_ff, v4_ff;
   logic [7:0]  r0_ff, g0_ff, b0_ff, r1_ff, g1_ff, b1_ff;
   logic [7:0]  r0_in, g0_in, b0_in, r1_in, g1_in, b1_in;
   logic [11:0] row1_ff, row2_ff, row3_ff;
   logic [10:0] col1_ff, col2_ff, col3_ff;
   logic [27:0] prod_ff, off2_ff, off3_ff;
   logic [15:0] ls0_ff, ls1_ff;
   logic [8:0]  rsum2_ff, bsum2_ff;
   logic [7:0]  y0_ff, y1_ff;
   logic signed [10:0] db_ff, dr_ff;
   logic signed [17:0] mb, mr;
   logic signed [9:0]  cb_s, cr_s;
   logic [9:0]  s4a, s4b;
   logic [8:0]  s2a, s2b;

   assign en    = !v4_ff || rsp_ready;
   assign q_pop = en && q_valid;

   always_comb begin
      if (!q_data.row[0]) begin
         s4a   = 10'(q_data.win[0]) + 10'(q_data.win[2]) + 10'(q_data.win[8])
                 + 10'(q_data.win[10]) + 10'd2;
         s4b   = 10'(q_data.win[1]) + 10'(q_data.win[4]) + 10'(q_data.win[6])
                 + 10'(q_data.win[9]) + 10'd2;
         r0_in = s4a[9:2];
         g0_in = s4b[9:2];
         b0_in = q_data.win[5];
         s2a   = 9'(q_data.win[2]) + 9'(q_data.win[10]) + 9'd1;
         s2b   = 9'(q_data.win[5]) + 9'(q_data.win[7]) + 9'd1;
         r1_in = s2a[8:1];
         b1_in = s2b[8:1];
         g1_in = q_data.win[6];
      end else begin
         s2a   = 9'(q_data.win[1]) + 9'(q_data.win[9]) + 9'd1;
         s2b   = 9'(q_data.win[4]) + 9'(q_data.win[6]) + 9'd1;
         b0_in = s2a[8:1];
         r0_in = s2b[8:1];
         g0_in = q_data.win[5];
         s4a   = 10'(q_data.win[1]) + 10'(q_data.win[3]) + 10'(q_data.win[9])
                 + 10'(q_data.win[11]) + 10'd2;
         s4b   = 10'(q_data.win[2]) + 10'(q_data.win[5]) + 10'(q_data.win[7])
                 + 10'(q_data.win[10]) + 10'd2;
         b1_in = s4a[9:2];
         g1_in = s4b[9:2];
         r1_in = q_data.win[6];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= q_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_comb begin
      mb   = 18'(db_ff) * 18'sd73;
      mr   = 18'(dr_ff) * 18'sd91;
      cb_s = 10'(mb >>> 8) + 10'sd128;
      cr_s = 10'(mr >>> 8) + 10'sd128;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // colors and row-times-stride product
         r0_ff   <= r0_in;
         g0_ff   <= g0_in;
         b0_ff   <= b0_in;
         r1_ff   <= r1_in;
         g1_ff   <= g1_in;
         b1_ff   <= b1_in;
         row1_ff <= q_data.row;
         col1_ff <= q_data.col;
         prod_ff <= 28'(q_data.row) * 28'(out_stride);
         // luma sums
         ls0_ff   <= 16'(r0_ff) * 16'd77 + 16'(g0_ff) * 16'd150 + 16'(b0_ff) * 16'd28;
         ls1_ff   <= 16'(r1_ff) * 16'd77 + 16'(g1_ff) * 16'd150 + 16'(b1_ff) * 16'd28;
         rsum2_ff <= 9'(r0_ff) + 9'(r1_ff);
         bsum2_ff <= 9'(b0_ff) + 9'(b1_ff);
         row2_ff  <= row1_ff;
         col2_ff  <= col1_ff;
         off2_ff  <= prod_ff + {16'd0, col1_ff, 1'b0};
         // luma never exceeds 254, so the top byte needs no clamp
         y0_ff   <= ls0_ff[15:8];
         y1_ff   <= ls1_ff[15:8];
         db_ff   <= 11'(bsum2_ff) - 11'(ls0_ff[15:8]) - 11'(ls1_ff[15:8]);
         dr_ff   <= 11'(rsum2_ff) - 11'(ls0_ff[15:8]) - 11'(ls1_ff[15:8]);
         row3_ff <= row2_ff;
         col3_ff <= col2_ff;
         off3_ff <= off2_ff;
         // chroma with saturation into the output register
         rsp_data.out_cb       <= cb_s[9] ? 8'd0 : (cb_s[8] ? 8'd255 : cb_s[7:0]);
         rsp_data.out_cr       <= cr_s[9] ? 8'd0 : (cr_s[8] ? 8'd255 : cr_s[7:0]);
         rsp_data.out_y_first  <= y0_ff;
         rsp_data.out_y_second <= y1_ff;
         rsp_data.out_row      <= row3_ff;
         rsp_data.out_col      <= col3_ff;
         rsp_data.out_offset   <= off3_ff;
      end
   end

   assign rsp_valid = v4_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (v4_ff && !rsp_ready) |=> (v4_ff && $stable(rsp_data))) else $error("result lost");
   a_pop_en: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> en) else $error("pop while stalled");
   a_pipe: assert property (@(posedge clock) disable iff (reset)
      (en && v3_ff) |=> v4_ff) else $error("stage lost");

endmodule
